// ----- rtl/topic_filter_matcher_top_macros.svh -----
// Assertion macros shared by the topic filter matcher RTL.
`ifndef TOPIC_FILTER_MATCHER_TOP_MACROS_SVH
`define TOPIC_FILTER_MATCHER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define TFM_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define TFM_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/tfm_pkg.sv -----
// Shared constants and types for the topic filter matcher.
package tfm_pkg;

   localparam int DataW    = 64;
   localparam int AddrW    = 6;
   localparam int LenW     = 6;
   localparam int PatWords = 4;
   localparam int PatBits  = PatWords * DataW;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   typedef enum logic [2:0] {
      REG_PATTERN_WORD_0    = 3'd0,
      REG_PATTERN_WORD_1    = 3'd1,
      REG_PATTERN_WORD_2    = 3'd2,
      REG_PATTERN_WORD_3    = 3'd3,
      REG_PATTERN_LENGTH    = 3'd4,
      REG_WILDCARDS_ENABLED = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic accept;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic walk_done;
      logic last_item;
   } sts_type;

endpackage

// ----- rtl/tfm_csr.sv -----
// Configuration registers and APB-style access for the topic filter matcher.
module tfm_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tfm_pkg::AddrW-1:0]   paddr,
   input  logic [tfm_pkg::DataW-1:0]   pwdata,
   output logic [tfm_pkg::DataW-1:0]   prdata,
   output logic                        pready,
   output logic [tfm_pkg::PatBits-1:0] pattern_flat,
   output logic [tfm_pkg::LenW-1:0]    pattern_length,
   output logic                        wildcards_enabled
);

   logic [tfm_pkg::DataW-1:0] word0_ff, word0_in;
   logic [tfm_pkg::DataW-1:0] word1_ff, word1_in;
   logic [tfm_pkg::DataW-1:0] word2_ff, word2_in;
   logic [tfm_pkg::DataW-1:0] word3_ff, word3_in;
   logic [tfm_pkg::LenW-1:0]  length_ff, length_in;
   logic                      wild_ff, wild_in;
   logic                      wr_en;
   tfm_pkg::reg_index_type    reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel & penable & pwrite;
   assign reg_index = tfm_pkg::reg_index_type'(paddr[tfm_pkg::AddrW-1:3]);

   always_comb begin
      word0_in  = word0_ff;
      word1_in  = word1_ff;
      word2_in  = word2_ff;
      word3_in  = word3_ff;
      length_in = length_ff;
      wild_in   = wild_ff;
      if (wr_en) begin
         unique case (reg_index)
            tfm_pkg::REG_PATTERN_WORD_0:    word0_in  = pwdata;
            tfm_pkg::REG_PATTERN_WORD_1:    word1_in  = pwdata;
            tfm_pkg::REG_PATTERN_WORD_2:    word2_in  = pwdata;
            tfm_pkg::REG_PATTERN_WORD_3:    word3_in  = pwdata;
            tfm_pkg::REG_PATTERN_LENGTH:    length_in = pwdata[tfm_pkg::LenW-1:0];
            tfm_pkg::REG_WILDCARDS_ENABLED: wild_in   = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         tfm_pkg::REG_PATTERN_WORD_0:    prdata = word0_ff;
         tfm_pkg::REG_PATTERN_WORD_1:    prdata = word1_ff;
         tfm_pkg::REG_PATTERN_WORD_2:    prdata = word2_ff;
         tfm_pkg::REG_PATTERN_WORD_3:    prdata = word3_ff;
         tfm_pkg::REG_PATTERN_LENGTH: begin
            prdata = tfm_pkg::DataW'(length_ff);
         end
         tfm_pkg::REG_WILDCARDS_ENABLED: begin
            prdata = tfm_pkg::DataW'(wild_ff);
         end
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word0_ff  <= '0;
         word1_ff  <= '0;
         word2_ff  <= '0;
         word3_ff  <= '0;
         length_ff <= '0;
         wild_ff   <= 1'b0;
      end else begin
         word0_ff  <= word0_in;
         word1_ff  <= word1_in;
         word2_ff  <= word2_in;
         word3_ff  <= word3_in;
         length_ff <= length_in;
         wild_ff   <= wild_in;
      end
   end

   assign pattern_flat      = {word3_ff, word2_ff, word1_ff, word0_ff};
   assign pattern_length    = length_ff;
   assign wildcards_enabled = wild_ff;

endmodule

// ----- rtl/tfm_dpath.sv -----
// Datapath of the topic filter matcher: exact compare, wildcard walk, result register.
`include "topic_filter_matcher_top_macros.svh"

module tfm_dpath #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tfm_pkg::cmd_type            cmd,
   output tfm_pkg::sts_type            sts,
   input  logic [7:0]                  req_topic_byte,
   input  logic                        req_last_byte,
   input  logic                        req_empty_topic,
   input  logic [tfm_pkg::PatBits-1:0] pattern_flat,
   input  logic [tfm_pkg::LenW-1:0]    pattern_length,
   input  logic                        wildcards_enabled,
   output logic                        rsp_matched
);

   localparam int CntW = $clog2(MAX_PATTERN + 2);
   localparam int IdxW = $clog2(MAX_PATTERN);
   localparam logic [CntW-1:0] CntMax = CntW'(MAX_PATTERN + 1);
   localparam logic [CntW-1:0] PatMax = CntW'(MAX_PATTERN);

   logic [7:0]      pat_bytes [MAX_PATTERN];
   logic [CntW-1:0] len_eff;
   logic [CntW-1:0] rd_idx;
   logic [7:0]      rd_byte;
   logic            skip_hold;
   logic            exact_ok;
   logic            walk_ok;
   logic            walk_done;

   logic [CntW-1:0] pos_ff, pos_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            skip_ff, skip_in;
   logic            vknown_ff, vknown_in;
   logic            vval_ff, vval_in;
   logic            exact_ff, exact_in;
   logic [7:0]      byte_ff, byte_in;
   logic            last_ff, last_in;
   logic            empty_ff, empty_in;
   logic            matched_ff, matched_in;

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pat
      assign pat_bytes[k] = pattern_flat[8*k +: 8];
   end

   assign len_eff = (pattern_length > tfm_pkg::LenW'(MAX_PATTERN)) ? PatMax
                                                                  : CntW'(pattern_length);
   assign rd_idx  = cmd.accept ? count_ff : pos_ff;
   assign rd_byte = (rd_idx < PatMax) ? pat_bytes[rd_idx[IdxW-1:0]] : 8'h00;

   assign skip_hold = skip_ff && (byte_ff != tfm_pkg::CH_SLASH);
   assign exact_ok  = exact_ff && (count_ff == len_eff);
   assign walk_ok   = vknown_ff ? vval_ff : (pos_ff == len_eff);

   always_comb begin
      pos_in     = pos_ff;
      count_in   = count_ff;
      skip_in    = skip_ff;
      vknown_in  = vknown_ff;
      vval_in    = vval_ff;
      exact_in   = exact_ff;
      byte_in    = byte_ff;
      last_in    = last_ff;
      empty_in   = empty_ff;
      matched_in = matched_ff;
      walk_done  = 1'b1;

      if (cmd.accept) begin
         byte_in  = req_topic_byte;
         last_in  = req_last_byte;
         empty_in = req_empty_topic;
         if (!req_empty_topic) begin
            if (count_ff < len_eff) begin
               exact_in = exact_ff && (rd_byte == req_topic_byte);
            end else begin
               exact_in = 1'b0;
            end
            if (count_ff < CntMax) begin
               count_in = count_ff + CntW'(1);
            end
         end
      end

      if (cmd.step && !empty_ff && !vknown_ff && !skip_hold) begin
         skip_in = 1'b0;
         if (pos_ff >= len_eff) begin
            vknown_in = 1'b1;
            vval_in   = 1'b0;
         end else begin
            case (rd_byte)
               tfm_pkg::CH_PLUS: begin
                  skip_in   = 1'b1;
                  pos_in    = pos_ff + CntW'(1);
                  walk_done = 1'b0;
               end
               tfm_pkg::CH_HASH: begin
                  vknown_in = 1'b1;
                  vval_in   = 1'b1;
               end
               default: begin
                  if (rd_byte != byte_ff) begin
                     vknown_in = 1'b1;
                     vval_in   = 1'b0;
                  end else begin
                     pos_in = pos_ff + CntW'(1);
                  end
               end
            endcase
         end
      end

      if (cmd.finish) begin
         if (empty_ff) begin
            matched_in = (len_eff == '0);
         end else begin
            matched_in = exact_ok || (wildcards_enabled && walk_ok);
         end
         pos_in    = '0;
         count_in  = '0;
         skip_in   = 1'b0;
         vknown_in = 1'b0;
         vval_in   = 1'b0;
         exact_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         count_ff  <= '0;
         skip_ff   <= 1'b0;
         vknown_ff <= 1'b0;
         vval_ff   <= 1'b0;
         exact_ff  <= 1'b1;
      end else begin
         pos_ff    <= pos_in;
         count_ff  <= count_in;
         skip_ff   <= skip_in;
         vknown_ff <= vknown_in;
         vval_ff   <= vval_in;
         exact_ff  <= exact_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      last_ff    <= last_in;
      empty_ff   <= empty_in;
      matched_ff <= matched_in;
   end

   assign sts.walk_done = walk_done;
   assign sts.last_item = last_ff | empty_ff;
   assign rsp_matched   = matched_ff;

   `TFM_ASSERT_IMPL(a_count_saturates, clock, reset, 1'b1, count_ff <= CntMax, "byte count past saturation")
   `TFM_ASSERT_NEXT(a_clear_after_finish, clock, reset, cmd.finish, (pos_ff == '0) && (count_ff == '0) && exact_ff && !vknown_ff && !skip_ff, "topic state not cleared")

endmodule

// ----- rtl/tfm_ctrl.sv -----
// Controller state machine of the topic filter matcher.
`include "topic_filter_matcher_top_macros.svh"

module tfm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tfm_pkg::cmd_type cmd,
   input  tfm_pkg::sts_type sts
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.step = 1'b1;
            if (sts.walk_done) begin
               state_in = sts.last_item ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `TFM_ASSERT_IMPL(a_no_overwrite, clock, reset, cmd.finish, !rsp_valid_ff || rsp_ready, "result register overwritten")
   `TFM_ASSERT_NEXT(a_accept_walks, clock, reset, req_valid && req_ready, state_ff == ST_WALK && !req_ready, "accepted request not walked")

endmodule

// ----- rtl/topic_filter_matcher_top.sv -----
// Top level of the topic filter matcher: registers, controller and datapath.
// Each request carries one topic byte. ST_IDLE accepts the byte and compares it with the
// pattern byte at the topic position; ST_WALK then reads one pattern byte through the
// shared pattern read mux, and repeats once for every plus sign in the pattern that the
// walk reaches. The last byte and an empty topic then go through ST_FINISH to load the
// result register, and stall there while the previous verdict is still waiting to be
// taken; the register holds the verdict until taken while the next topic streams in.
// Pattern registers sit at byte address 8*i on the 64-bit configuration port; the user
// must write them only while no topic is pending, as the block does not enforce it.
module topic_filter_matcher_top #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_topic_byte,
   input  logic                      req_last_byte,
   input  logic                      req_empty_topic,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_matched,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [tfm_pkg::AddrW-1:0] paddr,
   input  logic [tfm_pkg::DataW-1:0] pwdata,
   output logic [tfm_pkg::DataW-1:0] prdata,
   output logic                      pready
);

   tfm_pkg::cmd_type                 cmd;
   tfm_pkg::sts_type                 sts;
   logic [tfm_pkg::PatBits-1:0]      pattern_flat;
   logic [tfm_pkg::LenW-1:0]         pattern_length;
   logic                             wildcards_enabled;

   tfm_csr u_csr (
      .clock             (clock),
      .reset             (reset),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .pattern_flat      (pattern_flat),
      .pattern_length    (pattern_length),
      .wildcards_enabled (wildcards_enabled)
   );

   tfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   tfm_dpath #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_topic_byte    (req_topic_byte),
      .req_last_byte     (req_last_byte),
      .req_empty_topic   (req_empty_topic),
      .pattern_flat      (pattern_flat),
      .pattern_length    (pattern_length),
      .wildcards_enabled (wildcards_enabled),
      .rsp_matched       (rsp_matched)
   );

endmodule
